@@ rtl/gffa_pkg.sv @@
// shared constants, codes and control types of the granule allocator
package gffa_pkg;

  // table geometry
  localparam int unsigned BLK_N = 64;
  localparam int unsigned IDX_W = $clog2(BLK_N);

  // granule constants
  localparam logic [15:0] GRANULE_MASK  = 16'hffff;
  localparam logic [16:0] FIRST_GRANULE = 17'd16;
  localparam logic [16:0] TOP_CAP       = 17'd65535;
  localparam logic [31:0] MAX_SIZE      = 32'hffff0000;
  localparam logic [16:0] TOP_RESET     = 17'd256;

  // request codes
  localparam logic [2:0] OP_ALLOC   = 3'd0;
  localparam logic [2:0] OP_FREE    = 3'd1;
  localparam logic [2:0] OP_COMMIT  = 3'd2;
  localparam logic [2:0] OP_QUERY   = 3'd3;
  localparam logic [2:0] OP_REALLOC = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOMEM = 2'd1;
  localparam logic [1:0] ST_INVAL = 2'd2;

  // kind of table scan
  typedef enum logic [1:0] {
    MODE_FIND  = 2'd0,
    MODE_PLACE = 2'd1,
    MODE_SKIP  = 2'd2,
    MODE_GAP   = 2'd3
  } mode_t;

  // controller to datapath
  typedef struct packed {
    logic       latch;
    logic       pass_go;
    mode_t      mode;
    logic       gap_step;
    logic       write_entry;
    logic       drop_found;
    logic       load_out;
    logic [1:0] resp;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       pass_done;
    logic       found;
    logic       slot_ok;
    logic       size_ok;
    logic       hit;
    logic       fits;
    logic       cur_at_lim;
    logic       gap_end;
    logic       commit_ok;
    logic       out_busy;
    logic [2:0] op;
  } stat_t;

endpackage

@@ rtl/gffa_req_if.sv @@
// request channel: valid/ready and request payload
interface gffa_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [31:0] size;
  logic [31:0] address;

  modport source (output valid, output op, output size, output address, input ready);
  modport sink   (input valid, input op, input size, input address, output ready);
endinterface

@@ rtl/gffa_rsp_if.sv @@
// result channel: valid/ready and result payload
interface gffa_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] base_address;
  logic [31:0] avail_bytes;
  logic [31:0] largest_bytes;
  logic [31:0] move_bytes;

  modport source (output valid, output status, output base_address, output avail_bytes,
                  output largest_bytes, output move_bytes, input ready);
  modport sink   (input valid, input status, input base_address, input avail_bytes,
                  input largest_bytes, input move_bytes, output ready);
endinterface

@@ rtl/gffa_datapath.sv @@
// block table, scan engine, cursor arithmetic and result registers
module gffa_datapath
  import gffa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [2:0]  in_op,
  input  logic [31:0] in_size,
  input  logic [31:0] in_address,
  input  logic        cfg_we,
  input  logic [16:0] cfg_wdata,
  input  cmd_t        cmd,
  output stat_t       stat,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_base_address,
  output logic [31:0] out_avail_bytes,
  output logic [31:0] out_largest_bytes,
  output logic [31:0] out_move_bytes
);

  // block table memory and valid bits
  logic [15:0]      mem_base [BLK_N];
  logic [15:0]      mem_size [BLK_N];
  logic [BLK_N-1:0] valid_r;
  logic [BLK_N-1:0] set_mask;
  logic [BLK_N-1:0] clr_mask;

  logic [16:0] top_r;
  logic [16:0] lim;

  // latched request
  logic [2:0]  op_r;
  logic [31:0] size_r;
  logic [15:0] n_r;
  logic        size_ok_r;
  logic        commit_ok_r;
  logic [15:0] addr_hi_r;
  logic        addr_al_r;

  // scan sequencing
  logic [IDX_W:0]   idx_r;
  logic             active_r;
  logic             rd_vld_r;
  logic [IDX_W-1:0] rd_idx_r;
  mode_t            mode_r;
  logic [15:0]      rd_base_r;
  logic [15:0]      rd_size_r;
  logic             pass_done;

  // scan results
  logic [16:0]      cur_r, cur_nxt;
  logic [16:0]      m_r, m_nxt;
  logic [16:0]      total_r, total_nxt;
  logic [16:0]      best_r, best_nxt;
  logic             hit_r, hit_nxt;
  logic             found_r, found_nxt;
  logic [IDX_W-1:0] found_idx_r, found_idx_nxt;
  logic [15:0]      old_size_r, old_size_nxt;
  logic             slot_ok_r, slot_ok_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt;

  logic        ent_ok;
  logic [16:0] ent_end;
  logic [16:0] ent_b;
  logic [17:0] cur_plus_n;
  logic [16:0] gap;
  logic [32:0] commit_end;
  logic [16:0] n_full;
  logic [31:0] old_bytes;
  logic        placed_ok;

  assign lim        = (top_r < TOP_CAP) ? top_r : TOP_CAP;
  assign ent_ok     = rd_vld_r & valid_r[rd_idx_r];
  assign ent_b      = {1'b0, rd_base_r};
  assign ent_end    = ent_b + {1'b0, rd_size_r};
  assign cur_plus_n = {1'b0, cur_r} + {2'b00, n_r};
  assign gap        = m_r - cur_r;
  assign commit_end = {1'b0, in_address} + {1'b0, in_size};
  assign n_full     = {1'b0, in_size[31:16]} + {16'd0, |(in_size[15:0] & GRANULE_MASK)};
  assign old_bytes  = {old_size_r, 16'h0000};
  assign pass_done  = active_r & idx_r[IDX_W] & ~rd_vld_r;
  assign set_mask   = {{(BLK_N-1){1'b0}}, cmd.write_entry} << slot_r;
  assign clr_mask   = {{(BLK_N-1){1'b0}}, cmd.drop_found} << found_idx_r;
  assign placed_ok  = (cmd.resp == ST_OK) && (op_r == OP_ALLOC || op_r == OP_REALLOC);

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r <= TOP_RESET;
    end else if (cfg_we) begin
      top_r <= cfg_wdata;
    end
  end

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r        <= in_op;
      size_r      <= in_size;
      n_r         <= n_full[15:0];
      size_ok_r   <= (in_size != 32'd0) && (in_size <= MAX_SIZE);
      commit_ok_r <= (in_size != 32'd0) && !commit_end[32] &&
                     (commit_end <= {top_r, 16'h0000});
      addr_hi_r   <= in_address[31:16];
      addr_al_r   <= (in_address[15:0] == 16'h0000);
    end
  end

  // scan index and registered table read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      rd_vld_r <= 1'b0;
      idx_r    <= '0;
    end else if (cmd.pass_go) begin
      active_r <= 1'b1;
      rd_vld_r <= 1'b0;
      idx_r    <= '0;
      mode_r   <= cmd.mode;
    end else if (active_r) begin
      if (!idx_r[IDX_W]) begin
        idx_r    <= idx_r + 1'b1;
        rd_vld_r <= 1'b1;
        rd_idx_r <= idx_r[IDX_W-1:0];
      end else begin
        rd_vld_r <= 1'b0;
        if (!rd_vld_r) begin
          active_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_entry) begin
      mem_base[slot_r] <= cur_r[15:0];
      mem_size[slot_r] <= n_r;
    end
    rd_base_r <= mem_base[idx_r[IDX_W-1:0]];
    rd_size_r <= mem_size[idx_r[IDX_W-1:0]];
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= (valid_r | set_mask) & ~clr_mask;
    end
  end

  // per-entry evaluation of the scan
  always_comb begin
    cur_nxt       = cur_r;
    m_nxt         = m_r;
    total_nxt     = total_r;
    best_nxt      = best_r;
    hit_nxt       = hit_r;
    found_nxt     = found_r;
    found_idx_nxt = found_idx_r;
    old_size_nxt  = old_size_r;
    slot_ok_nxt   = slot_ok_r;
    slot_nxt      = slot_r;
    if (cmd.latch) begin
      cur_nxt     = FIRST_GRANULE;
      total_nxt   = '0;
      best_nxt    = '0;
      found_nxt   = 1'b0;
      slot_ok_nxt = 1'b0;
    end
    if (cmd.pass_go) begin
      hit_nxt = 1'b0;
      m_nxt   = lim;
    end
    if (cmd.gap_step) begin
      total_nxt = total_r + gap;
      if (gap > best_r) begin
        best_nxt = gap;
      end
      cur_nxt = m_r;
    end
    if (rd_vld_r) begin
      case (mode_r)
        MODE_FIND: begin
          if (ent_ok && !found_r && addr_al_r && (rd_base_r == addr_hi_r)) begin
            found_nxt     = 1'b1;
            found_idx_nxt = rd_idx_r;
            old_size_nxt  = rd_size_r;
          end
          if (!valid_r[rd_idx_r] && !slot_ok_r) begin
            slot_ok_nxt = 1'b1;
            slot_nxt    = rd_idx_r;
          end
        end
        MODE_PLACE: begin
          if (ent_ok && (cur_r < ent_end) && ({1'b0, ent_b} < cur_plus_n)) begin
            cur_nxt = ent_end;
            hit_nxt = 1'b1;
          end
        end
        MODE_SKIP: begin
          if (ent_ok && (ent_b <= cur_r) && (cur_r < ent_end)) begin
            cur_nxt = ent_end;
            hit_nxt = 1'b1;
          end
        end
        MODE_GAP: begin
          if (ent_ok && (ent_b >= cur_r) && (ent_b < m_r)) begin
            m_nxt = ent_b;
          end
        end
        default: begin
          hit_nxt = hit_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    m_r         <= m_nxt;
    total_r     <= total_nxt;
    best_r      <= best_nxt;
    hit_r       <= hit_nxt;
    found_r     <= found_nxt;
    found_idx_r <= found_idx_nxt;
    old_size_r  <= old_size_nxt;
    slot_ok_r   <= slot_ok_nxt;
    slot_r      <= slot_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status        <= cmd.resp;
      out_base_address  <= placed_ok ? {cur_r[15:0], 16'h0000} : 32'd0;
      out_move_bytes    <= (cmd.resp == ST_OK && op_r == OP_REALLOC) ?
                           ((old_bytes < size_r) ? old_bytes : size_r) : 32'd0;
      out_avail_bytes   <= (op_r == OP_QUERY) ? {total_r[15:0], 16'h0000} : 32'd0;
      out_largest_bytes <= (op_r == OP_QUERY) ? {best_r[15:0], 16'h0000} : 32'd0;
    end
  end

  // status towards the controller
  always_comb begin
    stat.pass_done  = pass_done;
    stat.found      = found_r;
    stat.slot_ok    = slot_ok_r;
    stat.size_ok    = size_ok_r;
    stat.hit        = hit_r;
    stat.fits       = (cur_plus_n <= {1'b0, lim});
    stat.cur_at_lim = (cur_r >= lim);
    stat.gap_end    = (m_r >= lim);
    stat.commit_ok  = commit_ok_r;
    stat.out_busy   = out_valid & ~out_ready;
    stat.op         = op_r;
  end

endmodule

@@ rtl/gffa_ctrl.sv @@
// request sequencer: decodes the request and orders the table scans
module gffa_ctrl
  import gffa_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DISP  = 7'b0000010,
    S_FIND  = 7'b0000100,
    S_PLACE = 7'b0001000,
    S_SKIP  = 7'b0010000,
    S_GAP   = 7'b0100000,
    S_RESP  = 7'b1000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] resp_r, resp_nxt;

  assign in_ready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    resp_nxt  = resp_r;
    cmd       = '0;
    cmd.resp  = resp_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (stat.op)
          OP_ALLOC, OP_FREE, OP_REALLOC: begin
            cmd.pass_go = 1'b1;
            cmd.mode    = MODE_FIND;
            state_nxt   = S_FIND;
          end
          OP_QUERY: begin
            if (stat.cur_at_lim) begin
              resp_nxt  = ST_OK;
              state_nxt = S_RESP;
            end else begin
              cmd.pass_go = 1'b1;
              cmd.mode    = MODE_SKIP;
              state_nxt   = S_SKIP;
            end
          end
          OP_COMMIT: begin
            resp_nxt  = stat.commit_ok ? ST_OK : ST_INVAL;
            state_nxt = S_RESP;
          end
          default: begin
            resp_nxt  = ST_INVAL;
            state_nxt = S_RESP;
          end
        endcase
      end
      S_FIND: begin
        if (stat.pass_done) begin
          state_nxt = S_RESP;
          if (stat.op == OP_FREE) begin
            cmd.drop_found = stat.found;
            resp_nxt       = stat.found ? ST_OK : ST_INVAL;
          end else if (stat.size_ok && stat.slot_ok &&
                       (stat.found || stat.op == OP_ALLOC)) begin
            cmd.pass_go = 1'b1;
            cmd.mode    = MODE_PLACE;
            state_nxt   = S_PLACE;
          end else begin
            resp_nxt = ST_NOMEM;
          end
        end
      end
      S_PLACE: begin
        if (stat.pass_done) begin
          if (!stat.fits) begin
            resp_nxt  = ST_NOMEM;
            state_nxt = S_RESP;
          end else if (stat.hit) begin
            cmd.pass_go = 1'b1;
            cmd.mode    = MODE_PLACE;
          end else begin
            cmd.write_entry = 1'b1;
            cmd.drop_found  = (stat.op == OP_REALLOC);
            resp_nxt        = ST_OK;
            state_nxt       = S_RESP;
          end
        end
      end
      S_SKIP: begin
        if (stat.pass_done) begin
          if (stat.hit) begin
            cmd.pass_go = 1'b1;
            cmd.mode    = MODE_SKIP;
          end else if (stat.cur_at_lim) begin
            resp_nxt  = ST_OK;
            state_nxt = S_RESP;
          end else begin
            cmd.pass_go = 1'b1;
            cmd.mode    = MODE_GAP;
            state_nxt   = S_GAP;
          end
        end
      end
      S_GAP: begin
        if (stat.pass_done) begin
          cmd.gap_step = 1'b1;
          if (stat.gap_end) begin
            resp_nxt  = ST_OK;
            state_nxt = S_RESP;
          end else begin
            cmd.pass_go = 1'b1;
            cmd.mode    = MODE_SKIP;
            state_nxt   = S_SKIP;
          end
        end
      end
      S_RESP: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      resp_r  <= ST_INVAL;
    end else begin
      state_r <= state_nxt;
      resp_r  <= resp_nxt;
    end
  end

endmodule

@@ rtl/granule_first_fit_allocator.sv @@
// Top level of the first-fit granule allocator. One request is handled at a
// time; the result waits in an output register while the next request is
// taken. All table work goes through one registered read port over the
// 64-entry block table, one entry per cycle. Allocate and reallocate take
// one pass to find the old block and a free slot, then placement passes,
// each of which may move the candidate base past several blocks, until a
// clean pass leaves it in place or the request no longer fits. Query walks
// the free runs with two passes per run (skip the occupied span, find the
// next block start) and a closing skip pass unless the last run reaches the
// top, plus one more pass whenever a skip has to step over further blocks.
// Valid bits are cleared by reset at once; there is no clearing pass. The
// user must write memory_top_granules through cfg_we / cfg_wdata only while
// no request is outstanding; the block does not enforce this.
module granule_first_fit_allocator
  import gffa_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  gffa_req_if.sink   in_ch,
  gffa_rsp_if.source out_ch,
  input  logic        cfg_we,
  input  logic [16:0] cfg_wdata
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  gffa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // table and arithmetic
  gffa_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_op             (in_ch.op),
    .in_size           (in_ch.size),
    .in_address        (in_ch.address),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .cmd               (cmd),
    .stat              (stat),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_status        (out_ch.status),
    .out_base_address  (out_ch.base_address),
    .out_avail_bytes   (out_ch.avail_bytes),
    .out_largest_bytes (out_ch.largest_bytes),
    .out_move_bytes    (out_ch.move_bytes)
  );

endmodule

@@ rtl/gffa_checker.sv @@
// port-level checks on the allocator results, bound to the top level
module gffa_checker
  import gffa_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [31:0] out_base_address,
  input logic [31:0] out_avail_bytes,
  input logic [31:0] out_largest_bytes,
  input logic [31:0] out_move_bytes
);

  // a result stays offered until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before taken");

  // only defined status codes
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_NOMEM || out_status == ST_INVAL))
    else $error("undefined status");

  // failures carry no base and no copy length
  a_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_base_address == 32'd0 && out_move_bytes == 32'd0)
    else $error("payload on failed request");

  // bases are granule aligned
  a_align: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_base_address[15:0] == 16'h0000)
    else $error("unaligned base");

  // longest run never exceeds the total
  a_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_largest_bytes <= out_avail_bytes)
    else $error("largest run above free total");

endmodule

bind granule_first_fit_allocator gffa_checker u_gffa_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_status        (out_ch.status),
  .out_base_address  (out_ch.base_address),
  .out_avail_bytes   (out_ch.avail_bytes),
  .out_largest_bytes (out_ch.largest_bytes),
  .out_move_bytes    (out_ch.move_bytes)
);
